@@ hw/rtl/swbt_pkg.sv @@
// ============================================================================
// swbt_pkg
// Shared types, codes and field widths for the sparse word bitset table.
// ============================================================================
package swbt_pkg;

    // Default sizing of the table
    localparam int SWBT_ENTRIES      = 16;
    localparam int SWBT_ELEMENT_BITS = 16;

    // Fixed field widths
    localparam int OP_W       = 2;
    localparam int ELEMENT_W  = 16;
    localparam int TAG_W      = 11;
    localparam int MASK_W     = 32;
    localparam int BIT_SHIFT  = 5;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_DUMP   = 2'd3
    } opcode_t;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One stored table entry
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [MASK_W-1:0] mask;
    } entry_t;

endpackage

@@ hw/rtl/swbt_if.sv @@
// ============================================================================
// swbt_if
// Valid/ready channels: command words in, result words out.
// ============================================================================
interface swbt_cmd_if
    import swbt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [ELEMENT_W-1:0] element;
    logic [TAG_W-1:0]     word_number;
    logic [MASK_W-1:0]    clear_bits;

    modport source (output valid, opcode, element, word_number, clear_bits,
                    input ready);
    modport sink   (input valid, opcode, element, word_number, clear_bits,
                    output ready);
endinterface

interface swbt_rsp_if
    import swbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  entry_word;
    logic [MASK_W-1:0] entry_bits;
    logic              entry_valid;
    logic              status;
    logic              last;

    modport source (output valid, entry_word, entry_bits, entry_valid, status, last,
                    input ready);
    modport sink   (input valid, entry_word, entry_bits, entry_valid, status, last,
                    output ready);
endinterface

@@ hw/rtl/swbt_mem.sv @@
// ============================================================================
// swbt_mem
// Entry memory: one write port, one read port, registered read data.
// ============================================================================
module swbt_mem
    import swbt_pkg::*;
#(
    parameter int DEPTH  = SWBT_ENTRIES,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/swbt_ctrl.sv @@
// ============================================================================
// swbt_ctrl
// Sequencer: walks the entry memory to find, append, modify, erase and dump entries,
// and holds the result word in an output register.
// ============================================================================
module swbt_ctrl
    import swbt_pkg::*;
#(
    parameter int ENTRIES      = SWBT_ENTRIES,
    parameter int ELEMENT_BITS = SWBT_ELEMENT_BITS,
    parameter int IDX_W        = 4,
    parameter int CNT_W        = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    swbt_cmd_if.sink         cmd,
    swbt_rsp_if.source       rsp,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output entry_t           mem_wdata,
    output logic             mem_re,
    output logic [IDX_W-1:0] mem_raddr,
    input  entry_t           mem_rdata
);

    localparam int USED_BITS = (ELEMENT_BITS < ELEMENT_W) ? ELEMENT_BITS : ELEMENT_W;
    localparam logic [ELEMENT_W-1:0] ELEM_MASK =
        ELEMENT_W'((64'd1 << USED_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_SHIFT,
        S_MOVE
    } state_t;

    state_t            state_reg, state_next;
    opcode_t           op_reg, op_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [MASK_W-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [TAG_W-1:0]  out_word_reg, out_word_next;
    logic [MASK_W-1:0] out_bits_reg, out_bits_next;
    logic              out_entry_valid_reg, out_entry_valid_next;
    logic              out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic [ELEMENT_W-1:0] elem_used;
    logic [CNT_W-1:0]     idx_plus;
    logic [MASK_W-1:0]    new_mask;
    logic                 out_free;
    logic                 hit;

    assign elem_used = cmd.element & ELEM_MASK;
    assign idx_plus  = idx_reg + CNT_W'(1);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign hit       = (mem_rdata.tag == tag_reg);
    assign new_mask  = (op_reg == OP_ADD) ? (mem_rdata.mask | bits_reg)
                                          : (mem_rdata.mask & ~bits_reg);

    assign cmd.ready = (state_reg == S_IDLE);

    // Sequence the table walk
    always_comb
    begin
        state_next           = state_reg;
        op_next              = op_reg;
        tag_next             = tag_reg;
        bits_next            = bits_reg;
        idx_next             = idx_reg;
        cnt_next             = cnt_reg;
        out_valid_next       = out_valid_reg && !rsp.ready;
        out_word_next        = out_word_reg;
        out_bits_next        = out_bits_reg;
        out_entry_valid_next = out_entry_valid_reg;
        out_status_next      = out_status_reg;
        out_last_next        = out_last_reg;
        mem_we               = 1'b0;
        mem_waddr            = idx_reg[IDX_W-1:0];
        mem_wdata            = mem_rdata;
        mem_re               = 1'b0;
        mem_raddr            = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                // Latch the command word
                if (cmd.valid)
                begin
                    op_next  = opcode_t'(cmd.opcode);
                    idx_next = '0;
                    if (opcode_t'(cmd.opcode) == OP_CLEAR)
                    begin
                        tag_next  = cmd.word_number;
                        bits_next = cmd.clear_bits;
                    end
                    else
                    begin
                        tag_next  = elem_used[ELEMENT_W-1:BIT_SHIFT];
                        bits_next = MASK_W'(1) << elem_used[BIT_SHIFT-1:0];
                    end
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                if (idx_reg == cnt_reg)
                begin
                    // End of table without a match
                    if (out_free)
                    begin
                        out_valid_next       = 1'b1;
                        out_word_next        = '0;
                        out_bits_next        = '0;
                        out_entry_valid_next = 1'b0;
                        out_status_next      = STATUS_OK;
                        out_last_next        = 1'b1;
                        if (op_reg == OP_ADD)
                        begin
                            if (cnt_reg < CNT_FULL)
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = cnt_reg[IDX_W-1:0];
                                mem_wdata.tag  = tag_reg;
                                mem_wdata.mask = bits_reg;
                                cnt_next       = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                out_status_next = STATUS_FULL;
                            end
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (op_reg == OP_DUMP)
                begin
                    // Emit one entry per visit
                    if (out_free)
                    begin
                        out_valid_next       = 1'b1;
                        out_word_next        = mem_rdata.tag;
                        out_bits_next        = mem_rdata.mask;
                        out_entry_valid_next = 1'b1;
                        out_status_next      = STATUS_OK;
                        out_last_next        = (idx_plus == cnt_reg);
                        idx_next             = idx_plus;
                        state_next           = (idx_plus == cnt_reg) ? S_IDLE : S_LOOK;
                    end
                end
                else if (hit)
                begin
                    if (new_mask == '0)
                    begin
                        state_next = S_SHIFT;
                    end
                    else if (out_free)
                    begin
                        // Write back the modified mask
                        mem_we               = 1'b1;
                        mem_wdata.mask       = new_mask;
                        out_valid_next       = 1'b1;
                        out_word_next        = '0;
                        out_bits_next        = '0;
                        out_entry_valid_next = 1'b0;
                        out_status_next      = STATUS_OK;
                        out_last_next        = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_plus;
                    state_next = S_LOOK;
                end
            end

            S_SHIFT:
            begin
                if (idx_plus == cnt_reg)
                begin
                    // Drop the tail entry
                    if (out_free)
                    begin
                        cnt_next             = cnt_reg - CNT_W'(1);
                        out_valid_next       = 1'b1;
                        out_word_next        = '0;
                        out_bits_next        = '0;
                        out_entry_valid_next = 1'b0;
                        out_status_next      = STATUS_OK;
                        out_last_next        = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_plus[IDX_W-1:0];
                    state_next = S_MOVE;
                end
            end

            S_MOVE:
            begin
                // Move the next entry down one place
                mem_we     = 1'b1;
                idx_next   = idx_plus;
                state_next = S_SHIFT;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            op_reg              <= OP_ADD;
            tag_reg             <= '0;
            bits_reg            <= '0;
            idx_reg             <= '0;
            cnt_reg             <= '0;
            out_valid_reg       <= 1'b0;
            out_word_reg        <= '0;
            out_bits_reg        <= '0;
            out_entry_valid_reg <= 1'b0;
            out_status_reg      <= STATUS_OK;
            out_last_reg        <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            op_reg              <= op_next;
            tag_reg             <= tag_next;
            bits_reg            <= bits_next;
            idx_reg             <= idx_next;
            cnt_reg             <= cnt_next;
            out_valid_reg       <= out_valid_next;
            out_word_reg        <= out_word_next;
            out_bits_reg        <= out_bits_next;
            out_entry_valid_reg <= out_entry_valid_next;
            out_status_reg      <= out_status_next;
            out_last_reg        <= out_last_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_word  = out_word_reg;
    assign rsp.entry_bits  = out_bits_reg;
    assign rsp.entry_valid = out_entry_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.last        = out_last_reg;

    // Table never grows past its capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count exceeds capacity");

    // Count moves by at most one per cycle
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            ((cnt_reg == $past(cnt_reg) + CNT_W'(1)) ||
             (cnt_reg == $past(cnt_reg) - CNT_W'(1))))
        else $error("entry count jumped");

    // Read data is used only after a read was issued
    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |->
            (($past(state_reg) == S_LOOK) || ($past(state_reg) == S_CHECK)))
        else $error("check without a preceding read");

    a_move_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> ($past(state_reg) == S_SHIFT))
        else $error("move without a preceding read");

    // Modify and compaction writes stay inside the live table
    a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != S_LOOK)) |-> (idx_reg < cnt_reg))
        else $error("write beyond live entries");

endmodule

@@ hw/rtl/sparse_word_bitset_table.sv @@
// ============================================================================
// sparse_word_bitset_table
// Sparse set of element numbers kept as an ordered, compacted table of
// (word index, 32-bit mask) entries in a single-port-read entry memory.
//
//   channel | dir | words per command       | contents
//   cmd     | in  | 1                       | opcode, element, word_number, clear_bits
//   rsp     | out | 1, or one per entry     | entry_word, entry_bits, entry_valid,
//           |     | on a dump               | status, last
//
// Steps: accept the command, then for each entry visited a memory read
// (S_LOOK) and a compare (S_CHECK); the search stops at the matching word,
// and a miss ends with a final S_LOOK step at the end of the table. An
// erase then moves each later entry down (read in S_SHIFT, write in S_MOVE)
// and drops the tail. A dump emits every entry, or one empty word if none.
// Reset clears the count and control state; memory needs no clearing pass.
// The result register lets a command be accepted while a word still waits;
// the walk pauses whenever it must emit and rsp is stalled.
// ============================================================================
module sparse_word_bitset_table
    import swbt_pkg::*;
#(
    parameter int ENTRIES      = SWBT_ENTRIES,
    parameter int ELEMENT_BITS = SWBT_ELEMENT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    swbt_cmd_if.sink    cmd,
    swbt_rsp_if.source  rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    // Walk and result control
    swbt_ctrl #(
        .ENTRIES      (ENTRIES),
        .ELEMENT_BITS (ELEMENT_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Entry storage
    swbt_mem #(
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
